// ===== rtl/bps_pkg.sv =====
// bps_pkg: shared types, widths, register codes and reset values
// for the blinn-phong pixel shader; no dependencies
package bps_pkg;

    localparam int NIN_W      = 17;
    localparam int DIV_STEPS  = 13;
    localparam int NOUT_W     = DIV_STEPS + 1;
    localparam int FRAC_SHIFT = 24;
    localparam int SQRT_STEPS = (2 * NIN_W + 2 + FRAC_SHIFT) / 2;
    localparam int NORM_LAT   = 3 + SQRT_STEPS + DIV_STEPS;

    localparam int POW_STEPS  = 255;
    localparam int B_W        = 29;
    localparam int P_W        = 45;
    localparam int P_LO_W     = 22;
    localparam int HL_W       = 31;
    localparam int DOT_W      = 30;

    localparam logic [P_W-1:0] POW_CAP = P_W'(64'd1 << 44);
    localparam logic [P_W-1:0] ONE_Q24 = P_W'(64'd1 << 24);

    localparam logic [47:0] RST_LIGHT_DIR = 48'h000010001000;
    localparam logic [47:0] RST_VIEW_POS  = 48'h300000000000;
    localparam logic [47:0] RST_AMBIENT   = 48'd1090948563763;
    localparam logic [47:0] RST_DIFFUSE   = 48'd5454742687744;
    localparam logic [47:0] RST_SPECULAR  = 48'd8796227241984;
    localparam logic [7:0]  RST_SHININESS = 8'd32;

    typedef enum logic [2:0] {
        CFG_LIGHT_DIR = 3'd0,
        CFG_VIEW_POS  = 3'd1,
        CFG_AMBIENT   = 3'd2,
        CFG_DIFFUSE   = 3'd3,
        CFG_SPECULAR  = 3'd4,
        CFG_SHININESS = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } t_frag;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_rgb;

    typedef struct packed {
        logic signed [NIN_W-1:0] x;
        logic signed [NIN_W-1:0] y;
        logic signed [NIN_W-1:0] z;
    } t_nvec_in;

    typedef struct packed {
        logic signed [NOUT_W-1:0] x;
        logic signed [NOUT_W-1:0] y;
        logic signed [NOUT_W-1:0] z;
    } t_nvec_out;

endpackage

// ===== rtl/bps_norm.sv =====
// bps_norm: pipelined vector normaliser (squares, digit-by-digit square root,
// restoring division per lane); depends on bps_pkg
module bps_norm (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  bps_pkg::t_nvec_in    i_vec,
    output bps_pkg::t_nvec_out   o_vec
);
    localparam int MW   = bps_pkg::NIN_W;
    localparam int SQW  = 2 * MW;
    localparam int LW   = SQW + 2;
    localparam int RADW = LW + bps_pkg::FRAC_SHIFT;
    localparam int RTW  = bps_pkg::SQRT_STEPS;
    localparam int REMW = RTW + 2;
    localparam int DW   = MW + bps_pkg::FRAC_SHIFT;
    localparam int QW   = bps_pkg::DIV_STEPS;
    localparam int CW   = RTW + QW;
    localparam int OW   = bps_pkg::NOUT_W;

    logic signed [MW-1:0] w_in [3];
    logic [MW-1:0]  n_mag [3];

    logic [MW-1:0]  r_s1_mag [3];
    logic           r_s1_neg [3];
    logic [SQW-1:0] r_s1_sq  [3];

    logic [RADW-1:0] r_rad  [RTW+1];
    logic [REMW-1:0] r_rem  [RTW+1];
    logic [RTW-1:0]  r_root [RTW+1];
    logic [MW-1:0]   r_smag [RTW+1][3];
    logic            r_sneg [RTW+1][3];

    logic [DW-1:0]  r_drem [QW][3];
    logic [QW-1:0]  r_dq   [QW][3];
    logic [RTW-1:0] r_ds   [QW];
    logic           r_dz   [QW];
    logic           r_dneg [QW][3];

    logic signed [OW-1:0] r_out [3];

    assign w_in[0] = i_vec.x;
    assign w_in[1] = i_vec.y;
    assign w_in[2] = i_vec.z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = w_in[i][MW-1] ? MW'(-w_in[i]) : MW'(w_in[i]);
        end
    end

    // squares, then sum of squares as radicand
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_mag[i] <= n_mag[i];
                r_s1_neg[i] <= w_in[i][MW-1];
                r_s1_sq[i]  <= SQW'(n_mag[i]) * SQW'(n_mag[i]);
                r_smag[0][i] <= r_s1_mag[i];
                r_sneg[0][i] <= r_s1_neg[i];
            end
            r_rad[0]  <= {LW'(r_s1_sq[0]) + LW'(r_s1_sq[1]) + LW'(r_s1_sq[2]),
                          bps_pkg::FRAC_SHIFT'(0)};
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar g = 0; g < RTW; g++) begin : g_sqrt
        logic [REMW+1:0] n_ext;
        logic [REMW+1:0] n_trial;
        logic            n_take;

        always_comb begin
            n_ext   = {r_rem[g], r_rad[g][RADW-1 -: 2]};
            n_trial = (REMW+2)'({r_root[g], 2'b01});
            n_take  = n_ext >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g+1]  <= r_rad[g] << 2;
                r_rem[g+1]  <= n_take ? REMW'(n_ext - n_trial) : REMW'(n_ext);
                r_root[g+1] <= {r_root[g][RTW-2:0], n_take};
                r_smag[g+1] <= r_smag[g];
                r_sneg[g+1] <= r_sneg[g];
            end
        end
    end

    // division of each magnitude by the root, one quotient bit per stage
    for (genvar g = 0; g < QW; g++) begin : g_div
        localparam int BIT = QW - 1 - g;
        logic [DW-1:0]  w_rem [3];
        logic [QW-1:0]  w_q   [3];
        logic [RTW-1:0] w_s;
        logic           w_z;
        logic           w_neg [3];
        logic [CW-1:0]  n_t;
        logic [CW-1:0]  n_r   [3];

        if (g == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    w_rem[i] = {r_smag[RTW][i], bps_pkg::FRAC_SHIFT'(0)};
                    w_q[i]   = '0;
                    w_neg[i] = r_sneg[RTW][i];
                end
                w_s = r_root[RTW];
                w_z = r_root[RTW] == '0;
            end
        end else begin : g_next
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    w_rem[i] = r_drem[g-1][i];
                    w_q[i]   = r_dq[g-1][i];
                    w_neg[i] = r_dneg[g-1][i];
                end
                w_s = r_ds[g-1];
                w_z = r_dz[g-1];
            end
        end

        always_comb begin
            n_t = CW'(w_s) << BIT;
            for (int i = 0; i < 3; i++) begin
                n_r[i] = CW'(w_rem[i]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (n_r[i] >= n_t) begin
                        r_drem[g][i] <= DW'(n_r[i] - n_t);
                        r_dq[g][i]   <= w_q[i] | (QW'(1) << BIT);
                    end else begin
                        r_drem[g][i] <= w_rem[i];
                        r_dq[g][i]   <= w_q[i];
                    end
                    r_dneg[g][i] <= w_neg[i];
                end
                r_ds[g] <= w_s;
                r_dz[g] <= w_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dz[QW-1]) begin
                    r_out[i] <= '0;
                end else if (r_dneg[QW-1][i]) begin
                    r_out[i] <= -$signed({1'b0, r_dq[QW-1][i]});
                end else begin
                    r_out[i] <= $signed({1'b0, r_dq[QW-1][i]});
                end
            end
        end
    end

    assign o_vec.x = r_out[0];
    assign o_vec.y = r_out[1];
    assign o_vec.z = r_out[2];

endmodule

// ===== rtl/blinn_phong_pixel_shade_top.sv =====
// blinn_phong_pixel_shade_top: fragment shading pipeline with config registers
// depends on bps_pkg and bps_norm
//
//  channel  | direction | handshake          | payload
//  fragment | in        | i_valid / o_stall  | i_data (bps_pkg::t_frag)
//  colour   | out       | o_valid / i_stall  | o_data (bps_pkg::t_rgb)
//  config   | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// one transaction per cycle enters while o_stall is low; the path runs through two
// normaliser passes, one split multiply per exponent step and the output arithmetic
// synchronous active-low reset clears valid bits and loads config registers with reset values
// the whole pipeline holds while a result waits under i_stall; o_stall follows it
module blinn_phong_pixel_shade_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bps_pkg::t_frag      i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output bps_pkg::t_rgb       o_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [47:0]         i_cfg_data
);
    localparam int NL   = bps_pkg::NORM_LAT;
    localparam int NW   = bps_pkg::NIN_W;
    localparam int OW   = bps_pkg::NOUT_W;
    localparam int PS   = bps_pkg::POW_STEPS;
    localparam int BW   = bps_pkg::B_W;
    localparam int PW   = bps_pkg::P_W;
    localparam int PLW  = bps_pkg::P_LO_W;
    localparam int PHW  = PW - PLW;
    localparam int HW   = bps_pkg::HL_W;
    localparam int DTW  = bps_pkg::DOT_W;
    localparam int PRW  = PW + BW;

    logic [47:0] r_light_dir;
    logic [47:0] r_view_pos;
    logic [47:0] r_ambient;
    logic [47:0] r_diffuse;
    logic [47:0] r_specular;
    logic [7:0]  r_shininess;

    logic w_en;

    logic                r_t0_vld;
    logic signed [15:0]  r_t0_n [3];
    bps_pkg::t_nvec_in   r_t0_vraw;
    bps_pkg::t_nvec_in   r_t0_lraw;

    bps_pkg::t_nvec_out  w_v;
    bps_pkg::t_nvec_out  w_l;
    bps_pkg::t_nvec_out  w_h;
    bps_pkg::t_nvec_in   w_hraw;

    logic                r_vld_d1 [NL];
    logic signed [15:0]  r_n_d1   [NL][3];
    logic                r_vld_d2 [NL];
    logic signed [15:0]  r_n_d2   [NL][3];
    bps_pkg::t_nvec_out  r_l_d2   [NL];

    logic signed [OW-1:0] w_lv [3];
    logic signed [OW-1:0] w_hv [3];

    logic                 r_d1_vld;
    logic signed [DTW-1:0] r_pl [3];
    logic signed [DTW-1:0] r_ph [3];
    logic signed [HW-1:0]  n_dnh;

    logic           r_pw_vld [PS+1];
    logic signed [HW-1:0] r_pw_hl [PS+1];
    logic [BW-1:0]  r_pw_b   [PS+1];
    logic [PW-1:0]  r_pw_p   [PS+1];

    logic           r_pa_vld [PS];
    logic signed [HW-1:0] r_pa_hl [PS];
    logic [BW-1:0]  r_pa_b   [PS];
    logic [PW-1:0]  r_pa_p   [PS];
    logic [PLW+BW-1:0] r_pa_lo [PS];
    logic [PHW+BW-1:0] r_pa_hi [PS];

    logic           r_o1_vld;
    logic [15:0]    r_o1_amb [3];
    logic signed [47:0] r_o1_dif [3];
    logic [16+PLW-1:0]  r_o1_slo [3];
    logic [16+PHW-1:0]  r_o1_shi [3];

    logic           r_o2_vld;
    logic signed [63:0] r_o2_sum [3];

    logic           r_o_valid;
    logic [15:0]    n_o_lane [3];
    logic [15:0]    r_o_lane [3];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_dir <= bps_pkg::RST_LIGHT_DIR;
            r_view_pos  <= bps_pkg::RST_VIEW_POS;
            r_ambient   <= bps_pkg::RST_AMBIENT;
            r_diffuse   <= bps_pkg::RST_DIFFUSE;
            r_specular  <= bps_pkg::RST_SPECULAR;
            r_shininess <= bps_pkg::RST_SHININESS;
        end else if (i_cfg_we) begin
            case (bps_pkg::t_cfg_idx'(i_cfg_idx))
                bps_pkg::CFG_LIGHT_DIR: r_light_dir <= i_cfg_data;
                bps_pkg::CFG_VIEW_POS:  r_view_pos  <= i_cfg_data;
                bps_pkg::CFG_AMBIENT:   r_ambient   <= i_cfg_data;
                bps_pkg::CFG_DIFFUSE:   r_diffuse   <= i_cfg_data;
                bps_pkg::CFG_SPECULAR:  r_specular  <= i_cfg_data;
                bps_pkg::CFG_SHININESS: r_shininess <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_en    = !(r_o_valid && i_stall);
    assign o_stall = r_o_valid && i_stall;
    assign o_valid = r_o_valid;

    // input stage: view vector and light vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_vld <= 1'b0;
        end else if (w_en) begin
            r_t0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0_n[0] <= i_data.normal_x;
            r_t0_n[1] <= i_data.normal_y;
            r_t0_n[2] <= i_data.normal_z;
            r_t0_vraw.x <= NW'($signed(r_view_pos[15:0]))  - NW'(i_data.pos_x);
            r_t0_vraw.y <= NW'($signed(r_view_pos[31:16])) - NW'(i_data.pos_y);
            r_t0_vraw.z <= NW'($signed(r_view_pos[47:32])) - NW'(i_data.pos_z);
            r_t0_lraw.x <= NW'($signed(r_light_dir[15:0]));
            r_t0_lraw.y <= NW'($signed(r_light_dir[31:16]));
            r_t0_lraw.z <= NW'($signed(r_light_dir[47:32]));
        end
    end

    bps_norm u_norm_view (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_vec (r_t0_vraw),
        .o_vec (w_v)
    );

    bps_norm u_norm_light (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_vec (r_t0_lraw),
        .o_vec (w_l)
    );

    assign w_hraw.x = NW'(w_l.x) + NW'(w_v.x);
    assign w_hraw.y = NW'(w_l.y) + NW'(w_v.y);
    assign w_hraw.z = NW'(w_l.z) + NW'(w_v.z);

    bps_norm u_norm_half (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_vec (w_hraw),
        .o_vec (w_h)
    );

    // delay lines alongside the normalisers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NL; k++) begin
                r_vld_d1[k] <= 1'b0;
                r_vld_d2[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld_d1[0] <= r_t0_vld;
            r_vld_d2[0] <= r_vld_d1[NL-1];
            for (int k = 1; k < NL; k++) begin
                r_vld_d1[k] <= r_vld_d1[k-1];
                r_vld_d2[k] <= r_vld_d2[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n_d1[0] <= r_t0_n;
            r_n_d2[0] <= r_n_d1[NL-1];
            r_l_d2[0] <= w_l;
            for (int k = 1; k < NL; k++) begin
                r_n_d1[k] <= r_n_d1[k-1];
                r_n_d2[k] <= r_n_d2[k-1];
                r_l_d2[k] <= r_l_d2[k-1];
            end
        end
    end

    assign w_lv[0] = r_l_d2[NL-1].x;
    assign w_lv[1] = r_l_d2[NL-1].y;
    assign w_lv[2] = r_l_d2[NL-1].z;
    assign w_hv[0] = w_h.x;
    assign w_hv[1] = w_h.y;
    assign w_hv[2] = w_h.z;

    // dot products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_vld <= 1'b0;
        end else if (w_en) begin
            r_d1_vld <= r_vld_d2[NL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pl[i] <= DTW'(r_n_d2[NL-1][i]) * DTW'(w_lv[i]);
                r_ph[i] <= DTW'(r_n_d2[NL-1][i]) * DTW'(w_hv[i]);
            end
        end
    end

    assign n_dnh = HW'(r_ph[0]) + HW'(r_ph[1]) + HW'(r_ph[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_pw_vld[0] <= r_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pw_hl[0] <= HW'(r_pl[0]) + HW'(r_pl[1]) + HW'(r_pl[2])
                        + $signed(HW'(bps_pkg::ONE_Q24));
            r_pw_b[0]  <= (n_dnh > 0) ? BW'(n_dnh) : '0;
            r_pw_p[0]  <= bps_pkg::ONE_Q24;
        end
    end

    // exponent chain: partial products, then sum, shift and cap
    for (genvar k = 0; k < PS; k++) begin : g_pow
        localparam logic [7:0] STEP = 8'(k);
        logic [PRW-1:0]  n_prod;
        logic [PRW-25:0] n_sh;
        logic [PW-1:0]   n_p;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pa_vld[k]   <= 1'b0;
                r_pw_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_pa_vld[k]   <= r_pw_vld[k];
                r_pw_vld[k+1] <= r_pa_vld[k];
            end
        end

        always_comb begin
            n_prod = (PRW'(r_pa_hi[k]) << PLW) + PRW'(r_pa_lo[k]);
            n_sh   = n_prod[PRW-1:24];
            if ((n_prod[PRW-1:64] != '0) || (n_sh > (PRW-24)'(bps_pkg::POW_CAP))) begin
                n_p = bps_pkg::POW_CAP;
            end else begin
                n_p = PW'(n_sh);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pa_hl[k] <= r_pw_hl[k];
                r_pa_b[k]  <= r_pw_b[k];
                r_pa_p[k]  <= r_pw_p[k];
                r_pa_lo[k] <= (PLW+BW)'(r_pw_p[k][PLW-1:0]) * (PLW+BW)'(r_pw_b[k]);
                r_pa_hi[k] <= (PHW+BW)'(r_pw_p[k][PW-1:PLW]) * (PHW+BW)'(r_pw_b[k]);
                r_pw_hl[k+1] <= r_pa_hl[k];
                r_pw_b[k+1]  <= r_pa_b[k];
                r_pw_p[k+1]  <= (STEP < r_shininess) ? n_p : r_pa_p[k];
            end
        end
    end

    // colour arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o1_vld  <= 1'b0;
            r_o2_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o1_vld  <= r_pw_vld[PS];
            r_o2_vld  <= r_o1_vld;
            r_o_valid <= r_o2_vld;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_o2_sum[i][63]) begin
                n_o_lane[i] = '0;
            end else if (r_o2_sum[i][62:41] != '0) begin
                n_o_lane[i] = 16'hFFFF;
            end else begin
                n_o_lane[i] = r_o2_sum[i][40:25];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_o1_amb[i] <= r_ambient[16*i +: 16];
                r_o1_dif[i] <= 48'($signed({1'b0, r_diffuse[16*i +: 16]})) * 48'(r_pw_hl[PS]);
                r_o1_slo[i] <= (16+PLW)'(r_specular[16*i +: 16])
                             * (16+PLW)'(r_pw_p[PS][PLW-1:0]);
                r_o1_shi[i] <= (16+PHW)'(r_specular[16*i +: 16])
                             * (16+PHW)'(r_pw_p[PS][PW-1:PLW]);
                r_o2_sum[i] <= $signed(64'(r_o1_amb[i]) << 25) + 64'(r_o1_dif[i])
                             + $signed(((64'(r_o1_shi[i]) << PLW) + 64'(r_o1_slo[i])) << 1);
                r_o_lane[i] <= n_o_lane[i];
            end
        end
    end

    assign o_data.red   = r_o_lane[0];
    assign o_data.green = r_o_lane[1];
    assign o_data.blue  = r_o_lane[2];

endmodule

// ===== rtl/bps_chk.sv =====
// bps_chk: port-level checks on the shader top level, with its bind
// depends on bps_pkg and blinn_phong_pixel_shade_top
module bps_chk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            o_stall,
    input  bps_pkg::t_frag  i_data,
    input  logic            o_valid,
    input  logic            i_stall,
    input  bps_pkg::t_rgb   o_data,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [47:0]     i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("result changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind blinn_phong_pixel_shade_top bps_chk u_bps_chk (.*);
